// ----- rtl/hfrp_pkg.sv -----
// Package for the heading-frame relative position block.
// Holds shared widths, the configuration and pipeline payload types and
// elaboration-time helpers. Used by every module in rtl.
`default_nettype none

package hfrp_pkg;

   localparam int CordicStagesDefault = 16;

   localparam int PosW      = 32;
   localparam int QuatW     = 16;
   localparam int ProdQW    = 2 * QuatW;
   localparam int DiffW     = 34;
   localparam int VecW      = 36;
   localparam int FracShift = 28;
   localparam int GainW     = 29;
   localparam int SplitW    = 18;
   localparam int HighW     = VecW - SplitW;
   localparam int ProdW     = HighW + GainW;
   localparam int WideW     = 66;
   localparam int OutPreW   = WideW - FracShift;
   localparam int AddrW     = 4;
   localparam int CsrDataW  = 32;

   localparam logic signed [VecW-1:0]  UnitQ28   = VecW'(64'd1 << FracShift);
   localparam logic signed [WideW-1:0] RoundHalf = WideW'(64'd1 << (FracShift - 1));

   typedef enum logic [1:0] {
      RegOffsetX     = 2'd0,
      RegOffsetY     = 2'd1,
      RegOffsetZ     = 2'd2,
      RegOffsetValid = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic signed [PosW-1:0] offset_x;
      logic signed [PosW-1:0] offset_y;
      logic signed [PosW-1:0] offset_z;
      logic                   offset_valid;
   } hfrp_cfg_type;

   typedef struct packed {
      logic signed [VecW-1:0] cx;
      logic signed [VecW-1:0] cy;
      logic signed [VecW-1:0] px;
      logic signed [VecW-1:0] py;
      logic                   degen;
      logic signed [PosW-1:0] vert;
   } hfrp_vec_type;

   function automatic logic [63:0] cordic_p(input int stages);
      logic [63:0] p;
      p = 64'd1 << 30;
      for (int i = 0; i < stages; i++) begin
         p = p + (p >> (2 * i));
      end
      return p;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] b;
      rem = v;
      r   = 64'd0;
      b   = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [PosW-1:0] sat32(input logic signed [OutPreW-1:0] v);
      logic signed [OutPreW-1:0] hi;
      logic signed [OutPreW-1:0] lo;
      hi = OutPreW'(64'sh7FFFFFFF);
      lo = -OutPreW'(64'sh80000000);
      if (v > hi) begin
         return PosW'(hi);
      end else if (v < lo) begin
         return PosW'(lo);
      end
      return PosW'(v);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hfrp_csr.sv -----
// Register file of the heading-frame relative position block.
// Holds the frame offset and its valid flag, written over an APB-style port.
// Depends on hfrp_pkg.
`default_nettype none

module hfrp_csr
   import hfrp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [AddrW-1:0]    csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0]      csr_prdata,
   output logic                     csr_pready,
   output hfrp_cfg_type             cfg
);

   hfrp_cfg_type cfg_ff;
   hfrp_cfg_type cfg_in;
   logic [1:0]   index;
   logic         wr_en;

   assign index      = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            RegOffsetX:     cfg_in.offset_x     = csr_pwdata;
            RegOffsetY:     cfg_in.offset_y     = csr_pwdata;
            RegOffsetZ:     cfg_in.offset_z     = csr_pwdata;
            RegOffsetValid: cfg_in.offset_valid = csr_pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         RegOffsetX:     csr_prdata = cfg_ff.offset_x;
         RegOffsetY:     csr_prdata = cfg_ff.offset_y;
         RegOffsetZ:     csr_prdata = cfg_ff.offset_z;
         RegOffsetValid: csr_prdata = {{(CsrDataW-1){1'b0}}, cfg_ff.offset_valid};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hfrp_front.sv -----
// Front end: difference vector, quaternion products, yaw vector and quarter turn.
// Two register stages; feeds the CORDIC chain. Depends on hfrp_pkg.
`default_nettype none

module hfrp_front
   import hfrp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         enable,
   input  wire logic         in_valid,
   input  wire logic [255:0] in_data,
   input  wire logic         in_ref_valid,
   input  hfrp_cfg_type      cfg,
   output logic              out_valid,
   output hfrp_vec_type      out_vec
);

   logic signed [PosW-1:0]  own_x, own_y, own_z, ref_x, ref_y, ref_z;
   logic signed [QuatW-1:0] qw, qx, qy, qz;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [DiffW-1:0]  dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic signed [ProdQW-1:0] wz_ff, xy_ff, yy_ff, zz_ff, wz_in, xy_in, yy_in, zz_in;

   logic                    s2_valid_ff;
   hfrp_vec_type            vec_ff, vec_in;
   logic signed [VecW-1:0]  cx_w, cy_w, px_w, py_w;

   assign own_x = in_data[31:0];
   assign own_y = in_data[63:32];
   assign own_z = in_data[95:64];
   assign ref_x = in_data[127:96];
   assign ref_y = in_data[159:128];
   assign ref_z = in_data[191:160];
   assign qw    = in_data[207:192];
   assign qx    = in_data[223:208];
   assign qy    = in_data[239:224];
   assign qz    = in_data[255:240];

   always_comb begin
      s1_valid_in = in_valid && in_ref_valid && cfg.offset_valid;
      dx_in = DiffW'(own_x) + DiffW'(cfg.offset_x) - DiffW'(ref_x);
      dy_in = DiffW'(own_y) + DiffW'(cfg.offset_y) - DiffW'(ref_y);
      dz_in = DiffW'(own_z) + DiffW'(cfg.offset_z) - DiffW'(ref_z);
      wz_in = ProdQW'(qw) * ProdQW'(qz);
      xy_in = ProdQW'(qx) * ProdQW'(qy);
      yy_in = ProdQW'(qy) * ProdQW'(qy);
      zz_in = ProdQW'(qz) * ProdQW'(qz);
   end

   always_comb begin
      cy_w = (VecW'(wz_ff) + VecW'(xy_ff)) <<< 1;
      cx_w = UnitQ28 - ((VecW'(yy_ff) + VecW'(zz_ff)) <<< 1);
      px_w = VecW'(dx_ff);
      py_w = VecW'(dy_ff);
      vec_in.degen = (cx_w == '0) && (cy_w == '0);
      vec_in.vert  = sat32(OutPreW'(dz_ff));
      vec_in.cx    = cx_w;
      vec_in.cy    = cy_w;
      vec_in.px    = px_w;
      vec_in.py    = py_w;
      if (cx_w[VecW-1]) begin
         if (!cy_w[VecW-1]) begin
            vec_in.cx = cy_w;
            vec_in.cy = -cx_w;
            vec_in.px = py_w;
            vec_in.py = -px_w;
         end else begin
            vec_in.cx = -cy_w;
            vec_in.cy = cx_w;
            vec_in.px = -py_w;
            vec_in.py = px_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz_ff  <= dz_in;
         wz_ff  <= wz_in;
         xy_ff  <= xy_in;
         yy_ff  <= yy_in;
         zz_ff  <= zz_in;
         vec_ff <= vec_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_vec   = vec_ff;

endmodule

`default_nettype wire

// ----- rtl/hfrp_cordic_stage.sv -----
// One registered CORDIC micro-rotation applied to the yaw and data vectors.
// Degenerate items pass unchanged. Depends on hfrp_pkg.
`default_nettype none

module hfrp_cordic_stage
   import hfrp_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    enable,
   input  wire logic    in_valid,
   input  hfrp_vec_type in_vec,
   output logic         out_valid,
   output hfrp_vec_type out_vec
);

   logic                   valid_ff;
   hfrp_vec_type           vec_ff, vec_in;
   logic signed [VecW-1:0] ax, ay, bx, by;

   always_comb begin
      ax     = $signed(in_vec.cy) >>> SHIFT;
      ay     = $signed(in_vec.cx) >>> SHIFT;
      bx     = $signed(in_vec.py) >>> SHIFT;
      by     = $signed(in_vec.px) >>> SHIFT;
      vec_in = in_vec;
      if (!in_vec.degen) begin
         if (!in_vec.cy[VecW-1]) begin
            vec_in.cx = in_vec.cx + ax;
            vec_in.cy = in_vec.cy - ay;
            vec_in.px = in_vec.px + bx;
            vec_in.py = in_vec.py - by;
         end else begin
            vec_in.cx = in_vec.cx - ax;
            vec_in.cy = in_vec.cy + ay;
            vec_in.px = in_vec.px - bx;
            vec_in.py = in_vec.py + by;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

`default_nettype wire

// ----- rtl/hfrp_gain.sv -----
// Gain correction, rounding and saturation of the rotated data vector.
// Split multiply, sum stage and output register. Depends on hfrp_pkg.
`default_nettype none

module hfrp_gain
   import hfrp_pkg::*;
#(
   parameter int CORDIC_STAGES = CordicStagesDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  hfrp_vec_type           in_vec,
   output logic                   out_valid,
   output logic signed [PosW-1:0] out_lateral,
   output logic signed [PosW-1:0] out_forward,
   output logic signed [PosW-1:0] out_vertical
);

   localparam logic [63:0] CordicP  = cordic_p(CORDIC_STAGES);
   localparam logic [63:0] CordicQ  = (64'd1 << 56) / CordicP;
   localparam logic [63:0] GainFull = isqrt64(CordicQ << 30);
   localparam logic signed [GainW-1:0] Gain = GainW'(GainFull);

   logic                    pa_valid_ff;
   logic signed [ProdW-1:0] fh_ff, fl_ff, lh_ff, ll_ff, fh_in, fl_in, lh_in, ll_in;
   logic                    pa_degen_ff;
   logic signed [VecW-1:0]  pa_px_ff, pa_py_ff;
   logic signed [PosW-1:0]  pa_vert_ff;

   logic                      pb_valid_ff;
   logic signed [OutPreW-1:0] pb_fwd_ff, pb_lat_ff, pb_fwd_in, pb_lat_in;
   logic signed [PosW-1:0]    pb_vert_ff;
   logic signed [WideW-1:0]   fwd_sum, lat_sum;

   logic                   out_valid_ff;
   logic signed [PosW-1:0] out_lat_ff, out_fwd_ff, out_vert_ff;

   always_comb begin
      fh_in = ProdW'($signed(in_vec.px[VecW-1:SplitW])) * ProdW'(Gain);
      fl_in = ProdW'($signed({1'b0, in_vec.px[SplitW-1:0]})) * ProdW'(Gain);
      lh_in = ProdW'($signed(in_vec.py[VecW-1:SplitW])) * ProdW'(Gain);
      ll_in = ProdW'($signed({1'b0, in_vec.py[SplitW-1:0]})) * ProdW'(Gain);
   end

   always_comb begin
      fwd_sum = (WideW'(fh_ff) <<< SplitW) + WideW'(fl_ff) + RoundHalf;
      lat_sum = (WideW'(lh_ff) <<< SplitW) + WideW'(ll_ff) + RoundHalf;
      if (pa_degen_ff) begin
         pb_fwd_in = OutPreW'(pa_px_ff);
         pb_lat_in = OutPreW'(pa_py_ff);
      end else begin
         pb_fwd_in = fwd_sum[WideW-1:FracShift];
         pb_lat_in = lat_sum[WideW-1:FracShift];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff  <= 1'b0;
         pb_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         pa_valid_ff  <= in_valid;
         pb_valid_ff  <= pa_valid_ff;
         out_valid_ff <= pb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fh_ff       <= fh_in;
         fl_ff       <= fl_in;
         lh_ff       <= lh_in;
         ll_ff       <= ll_in;
         pa_degen_ff <= in_vec.degen;
         pa_px_ff    <= in_vec.px;
         pa_py_ff    <= in_vec.py;
         pa_vert_ff  <= in_vec.vert;
         pb_fwd_ff   <= pb_fwd_in;
         pb_lat_ff   <= pb_lat_in;
         pb_vert_ff  <= pa_vert_ff;
         out_fwd_ff  <= sat32(pb_fwd_ff);
         out_lat_ff  <= sat32(pb_lat_ff);
         out_vert_ff <= pb_vert_ff;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_lateral  = out_lat_ff;
   assign out_forward  = out_fwd_ff;
   assign out_vertical = out_vert_ff;

endmodule

`default_nettype wire

// ----- rtl/heading_frame_relative_position.sv -----
// Heading-frame relative position: offset own position minus reference,
// rotated into the reference yaw frame. Top level; depends on hfrp_pkg,
// hfrp_csr, hfrp_front, hfrp_cordic_stage and hfrp_gain.
//
// Usage:
//   One pose beat on the req_ stream yields at most one beat on the rsp_
//   stream: lateral, forward and vertical offsets in Q16.16 metres,
//   saturated to 32 bits. A pose whose ref_valid flag is clear, or any pose
//   while offset_valid is clear, produces no result beat.
//   The csr_ port holds offset_x, offset_y, offset_z and offset_valid at
//   byte addresses 0, 4, 8 and 12; write it only while the block is idle.
//   From accept to rsp_tvalid a pose passes two front stages, one
//   register per CORDIC iteration and three gain and output stages.
//   One pose is accepted every cycle while the output is not stalled.
//   When the receiver holds rsp_tready low with a result waiting, every
//   stage freezes and req_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits and the CSR registers (offset_valid low).
`default_nettype none

module heading_frame_relative_position
   import hfrp_pkg::*;
#(
   parameter int CORDIC_STAGES = CordicStagesDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // own_x, own_y, own_z, ref_x, ref_y, ref_z, quat_w, quat_x, quat_y, quat_z
   input  wire logic [255:0]        req_tdata,
   // ref_valid
   input  wire logic [0:0]          req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // lateral, forward, vertical
   output logic [95:0]              rsp_tdata,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [AddrW-1:0]    csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0]      csr_prdata,
   output logic                     csr_pready
);

   hfrp_cfg_type           cfg;
   logic                   pipe_en;
   hfrp_vec_type           vec_chain [0:CORDIC_STAGES];
   logic [CORDIC_STAGES:0] valid_chain;
   logic signed [PosW-1:0] lateral, forward, vertical;

   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   hfrp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hfrp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (pipe_en),
      .in_valid     (req_tvalid && req_tready),
      .in_data      (req_tdata),
      .in_ref_valid (req_tuser[0]),
      .cfg          (cfg),
      .out_valid    (valid_chain[0]),
      .out_vec      (vec_chain[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      hfrp_cordic_stage #(
         .SHIFT (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_en),
         .in_valid  (valid_chain[i]),
         .in_vec    (vec_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_vec   (vec_chain[i+1])
      );
   end

   hfrp_gain #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_gain (
      .clock        (clock),
      .reset        (reset),
      .enable       (pipe_en),
      .in_valid     (valid_chain[CORDIC_STAGES]),
      .in_vec       (vec_chain[CORDIC_STAGES]),
      .out_valid    (rsp_tvalid),
      .out_lateral  (lateral),
      .out_forward  (forward),
      .out_vertical (vertical)
   );

   assign rsp_tdata = {vertical, forward, lateral};

   a_reset_clears_output : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   a_stall_freezes_chain : assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(valid_chain) && $stable(vec_chain[CORDIC_STAGES]))
      else $error("CORDIC chain moved during a stall");

   a_degen_not_rotated : assert property (@(posedge clock) disable iff (reset)
      (valid_chain[CORDIC_STAGES] && vec_chain[CORDIC_STAGES].degen)
         |-> (vec_chain[CORDIC_STAGES].cx == '0) && (vec_chain[CORDIC_STAGES].cy == '0))
      else $error("degenerate yaw vector was rotated");

endmodule

`default_nettype wire
